// ===== sv/lrsi_pkg.sv =====
package lrsi_pkg;

  localparam int unsigned IdxW        = 18;
  localparam int unsigned SizeW       = 6;
  localparam int unsigned PosW        = 5;
  localparam logic [IdxW-1:0]  IdxMax      = {IdxW{1'b1}};
  localparam logic [SizeW-1:0] MaxRingSize = 6'd32;
  localparam logic [SizeW-1:0] MinRing     = 6'd3;
  localparam logic [SizeW-1:0] FlatStep    = 6'd3;

  typedef struct packed {
    logic accept;
    logic emit;
    logic second;
    logic advance;
    logic finish;
  } lrsi_cmd_t;

  typedef struct packed {
    logic stitch_ok;
    logic slot_free;
    logic tri2_needed;
    logic last_step;
  } lrsi_stat_t;

  typedef struct packed {
    logic            ovf;
    logic [IdxW-1:0] val;
  } lrsi_sat_t;

  function automatic lrsi_sat_t lrsi_sat_add(input logic [IdxW-1:0] a,
                                             input logic [SizeW-1:0] b);
    logic [IdxW:0] sum;
    lrsi_sat_t     res;
    sum = {1'b0, a} + {{(IdxW + 1 - SizeW){1'b0}}, b};
    if (sum > {1'b0, IdxMax}) begin
      res.ovf = 1'b1;
      res.val = IdxMax;
    end else begin
      res.ovf = 1'b0;
      res.val = sum[IdxW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/lrsi_ctrl.sv =====
module lrsi_ctrl import lrsi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  lrsi_stat_t stat_i,
  output lrsi_cmd_t  cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StTri1   = 2'd1;
  localparam logic [1:0] StTri2   = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.stitch_ok ? StTri1 : StFinish;
        end
      end
      StTri1: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.tri2_needed) begin
            state_d = StTri2;
          end else begin
            cmd_o.advance = 1'b1;
            if (stat_i.last_step) begin
              state_d = StFinish;
            end
          end
        end
      end
      StTri2: begin
        if (stat_i.slot_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.second  = 1'b1;
          cmd_o.advance = 1'b1;
          state_d       = stat_i.last_step ? StFinish : StTri1;
        end
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.slot_free)
    else $error("triangle emitted into an occupied output slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && !stat_i.stitch_ok |=> state_q == StFinish)
    else $error("skipped ring did not go straight to base update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && !cmd_o.second && stat_i.tri2_needed |=> state_q == StTri2)
    else $error("second triangle of a step was dropped");

endmodule

// ===== sv/lrsi_datapath.sv =====
module lrsi_datapath import lrsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_data_i,
  input  logic [SizeW-1:0] ring_size_i,
  input  logic             new_mesh_i,
  input  lrsi_cmd_t        cmd_i,
  output lrsi_stat_t       stat_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [IdxW-1:0]  corner_first_o,
  output logic [IdxW-1:0]  corner_second_o,
  output logic [IdxW-1:0]  corner_third_o,
  output logic             overflow_o,
  output logic             last_o
);

  logic             flat_mode_q;
  logic [SizeW-1:0] prev_size_q;
  logic             have_prev_q;
  logic [IdxW-1:0]  prev_base_q;
  logic [IdxW-1:0]  next_base_q;
  logic [IdxW-1:0]  flat_count_q;
  logic             ovf_q;
  logic [SizeW-1:0] size_q;
  logic             abig_q;
  logic [SizeW-1:0] maj_q;
  logic [SizeW-1:0] mn_q;
  logic [PosW-1:0]  j_q;
  logic [PosW-1:0]  mc_q;
  logic [SizeW-1:0] r_q;
  logic             out_valid_q;
  logic [IdxW-1:0]  c0_q, c1_q, c2_q;
  logic             out_ovf_q, out_last_q;

  logic [SizeW-1:0] size_c;
  logic             abig_c;
  logic [SizeW:0]   r_sum;
  logic             carry;
  logic [SizeW-1:0] mc_inc;
  logic             last_step;
  logic [PosW-1:0]  jn, mnx;
  logic [PosW-1:0]  ac, an, bc, bn;
  lrsi_sat_t        iac, ian, ibc, ibn, f1, f2, f3, nb;
  logic             ovf_new;
  logic [IdxW-1:0]  d0, d1, d2;

  assign size_c = (ring_size_i > MaxRingSize) ? MaxRingSize : ring_size_i;
  assign abig_c = (prev_size_q >= size_c);

  assign stat_o.stitch_ok = !new_mesh_i && have_prev_q && (prev_size_q >= MinRing) &&
                            (size_c >= MinRing);
  assign stat_o.slot_free = !out_valid_q || !out_stall_i;

  assign r_sum     = {1'b0, r_q} + {1'b0, mn_q};
  assign carry     = (r_sum >= {1'b0, maj_q});
  assign mc_inc    = {1'b0, mc_q} + {{(SizeW - 1){1'b0}}, carry};
  assign last_step = (({1'b0, j_q} + 6'd1) == maj_q);
  assign jn        = last_step ? '0 : j_q + 5'd1;
  assign mnx       = last_step ? '0 : mc_inc[PosW-1:0];

  assign stat_o.tri2_needed = (mc_q != mnx);
  assign stat_o.last_step   = last_step;

  assign ac = abig_q ? j_q  : mc_q;
  assign an = abig_q ? jn   : mnx;
  assign bc = abig_q ? mc_q : j_q;
  assign bn = abig_q ? mnx  : jn;

  assign iac = lrsi_sat_add(prev_base_q, {1'b0, ac});
  assign ian = lrsi_sat_add(prev_base_q, {1'b0, an});
  assign ibc = lrsi_sat_add(next_base_q, {1'b0, bc});
  assign ibn = lrsi_sat_add(next_base_q, {1'b0, bn});
  assign f1  = lrsi_sat_add(flat_count_q, 6'd1);
  assign f2  = lrsi_sat_add(flat_count_q, 6'd2);
  assign f3  = lrsi_sat_add(flat_count_q, FlatStep);
  assign nb  = lrsi_sat_add(next_base_q, size_q);

  assign ovf_new = ovf_q | iac.ovf | ian.ovf | ibc.ovf | ibn.ovf | (flat_mode_q & f3.ovf);

  always_comb begin
    if (flat_mode_q) begin
      d0 = flat_count_q;
      d1 = f1.val;
      d2 = f2.val;
    end else if (cmd_i.second) begin
      d0 = ian.val;
      d1 = ibn.val;
      d2 = ibc.val;
    end else begin
      d0 = iac.val;
      d1 = ian.val;
      d2 = ibc.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      flat_mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_size_q  <= '0;
      have_prev_q  <= 1'b0;
      prev_base_q  <= '0;
      next_base_q  <= '0;
      flat_count_q <= '0;
      ovf_q        <= 1'b0;
    end else if (cmd_i.accept && new_mesh_i) begin
      prev_size_q  <= '0;
      have_prev_q  <= 1'b0;
      prev_base_q  <= '0;
      next_base_q  <= '0;
      flat_count_q <= '0;
      ovf_q        <= 1'b0;
    end else if (cmd_i.emit) begin
      ovf_q <= ovf_new;
      if (flat_mode_q) begin
        flat_count_q <= f3.val;
      end
    end else if (cmd_i.finish) begin
      next_base_q <= nb.val;
      ovf_q       <= ovf_q | nb.ovf;
      prev_base_q <= next_base_q;
      prev_size_q <= size_q;
      have_prev_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      size_q <= size_c;
      abig_q <= abig_c;
      maj_q  <= abig_c ? prev_size_q : size_c;
      mn_q   <= abig_c ? size_c : prev_size_q;
      j_q    <= '0;
      mc_q   <= '0;
      r_q    <= '0;
    end else if (cmd_i.advance) begin
      j_q  <= j_q + 5'd1;
      mc_q <= mc_inc[PosW-1:0];
      r_q  <= carry ? (r_sum[SizeW-1:0] - maj_q) : r_sum[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      c0_q       <= d0;
      c1_q       <= d1;
      c2_q       <= d2;
      out_ovf_q  <= ovf_new;
      out_last_q <= last_step && (cmd_i.second || !stat_o.tri2_needed);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign corner_first_o  = c0_q;
  assign corner_second_o = c1_q;
  assign corner_third_o  = c2_q;
  assign overflow_o      = out_ovf_q;
  assign last_o          = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> ({1'b0, j_q} < maj_q) && (r_q < maj_q))
    else $error("major step or remainder out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (mc_q <= j_q) && ({1'b0, mc_q} < mn_q))
    else $error("minor position ran ahead");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q && !(cmd_i.accept && new_mesh_i) |=> ovf_q)
    else $error("overflow flag cleared without a new mesh");

endmodule

// ===== sv/loft_ring_stitch_indexer_top.sv =====
// Per ring: accept, then one emit per triangle (up to 64), then one base update;
// a skipped ring emits no triangles, and an emit waits while the output slot is occupied.
// After accept, the first triangle passes the state register, then the output register.
// Throughput: single emit port, one triangle per cycle while the output is not stalled.
// Reset (rst_ni low, asynchronous) clears flat_mode, ring history, bases, flat counter,
// overflow flag and all handshake state; no clearing pass follows.
module loft_ring_stitch_indexer_top import lrsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [SizeW-1:0] ring_size_i,
  input  logic             new_mesh_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [IdxW-1:0]  corner_first_o,
  output logic [IdxW-1:0]  corner_second_o,
  output logic [IdxW-1:0]  corner_third_o,
  output logic             overflow_o,
  output logic             last_o
);

  lrsi_cmd_t  cmd;
  lrsi_stat_t stat;

  assign cfg_ready_o = 1'b1;

  lrsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lrsi_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .ring_size_i     (ring_size_i),
    .new_mesh_i      (new_mesh_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .corner_first_o  (corner_first_o),
    .corner_second_o (corner_second_o),
    .corner_third_o  (corner_third_o),
    .overflow_o      (overflow_o),
    .last_o          (last_o)
  );

endmodule

// ===== dv/loft_ring_stitch_checker.sv =====
module loft_ring_stitch_checker import lrsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [SizeW-1:0] ring_size_i,
  input  logic             new_mesh_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [IdxW-1:0]  corner_first_i,
  input  logic [IdxW-1:0]  corner_second_i,
  input  logic [IdxW-1:0]  corner_third_i,
  input  logic             overflow_i,
  input  logic             last_i,
  output int               err_count_o,
  output int               pending_o,
  output int               ring_count_o,
  output int               tri_count_o,
  output int               ovf_tri_count_o
);

  localparam int unsigned IdxLimit = (1 << IdxW) - 1;

  typedef struct packed {
    logic [IdxW-1:0] c0;
    logic [IdxW-1:0] c1;
    logic [IdxW-1:0] c2;
    logic            ovf;
    logic            last;
  } tri_t;

  logic        flat_mode_q;
  logic        have_prev;
  logic        ovf_seen;
  int unsigned prev_size;
  int unsigned prev_base;
  int unsigned next_base;
  int unsigned flat_count;
  tri_t        tri_q[$];
  int          errs;
  int          rings;
  int          tris;
  int          ovf_tris;

  function automatic int unsigned sat_idx(input int unsigned a, input int unsigned b);
    int unsigned s;
    s = a + b;
    if (s > IdxLimit) begin
      ovf_seen = 1'b1;
      return IdxLimit;
    end
    return s;
  endfunction

  function automatic void push_tri(input int unsigned c0, input int unsigned c1,
                                   input int unsigned c2, input logic fin);
    tri_t t;
    if (flat_mode_q) begin
      c0 = sat_idx(flat_count, 0);
      c1 = sat_idx(flat_count, 1);
      c2 = sat_idx(flat_count, 2);
      flat_count = sat_idx(flat_count, FlatStep);
    end
    t.c0   = c0[IdxW-1:0];
    t.c1   = c1[IdxW-1:0];
    t.c2   = c2[IdxW-1:0];
    t.ovf  = ovf_seen;
    t.last = fin;
    tri_q.insert(tri_q.size(), t);
  endfunction

  function automatic void stitch_ring(input logic [SizeW-1:0] raw, input logic fresh);
    int unsigned sz, cur_base, maj, mn, jn, mc, mnx, ac, an, bc, bn;
    int unsigned iac, ian, ibc, ibn;
    logic        a_big;
    if (fresh) begin
      prev_size  = 0;
      have_prev  = 1'b0;
      prev_base  = 0;
      next_base  = 0;
      flat_count = 0;
      ovf_seen   = 1'b0;
    end
    sz = raw;
    if (sz > MaxRingSize) sz = MaxRingSize;
    cur_base = next_base;
    if (have_prev && prev_size >= MinRing && sz >= MinRing) begin
      a_big = prev_size >= sz;
      maj   = a_big ? prev_size : sz;
      mn    = a_big ? sz : prev_size;
      for (int unsigned j = 0; j < maj; j++) begin
        jn  = (j + 1 == maj) ? 0 : j + 1;
        mc  = (j * mn) / maj;
        mnx = (jn * mn) / maj;
        ac  = a_big ? j : mc;
        an  = a_big ? jn : mnx;
        bc  = a_big ? mc : j;
        bn  = a_big ? mnx : jn;
        iac = sat_idx(prev_base, ac);
        ian = sat_idx(prev_base, an);
        ibc = sat_idx(cur_base, bc);
        ibn = sat_idx(cur_base, bn);
        push_tri(iac, ian, ibc, (j + 1 == maj) && (mc == mnx));
        if (mc != mnx) push_tri(ian, ibn, ibc, j + 1 == maj);
      end
    end
    next_base = sat_idx(cur_base, sz);
    prev_base = cur_base;
    prev_size = sz;
    have_prev = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    errs++;
    if (errs <= 200)
      $display("[%0t] triangle %0d %s: expected %0d, got %0d", $time, tris, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tri_t want;
    if (!rst_ni) begin
      flat_mode_q     = 1'b0;
      have_prev       = 1'b0;
      ovf_seen        = 1'b0;
      prev_size       = 0;
      prev_base       = 0;
      next_base       = 0;
      flat_count      = 0;
      tri_q.delete();
      errs            = 0;
      rings           = 0;
      tris            = 0;
      ovf_tris        = 0;
      err_count_o     <= 0;
      pending_o       <= 0;
      ring_count_o    <= 0;
      tri_count_o     <= 0;
      ovf_tri_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) flat_mode_q = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (tri_q.size() == 0) begin
          report_mismatch("arrived with nothing expected", 0, corner_first_i);
        end else begin
          want = tri_q.pop_front();
          if (corner_first_i !== want.c0)
            report_mismatch("corner_first", want.c0, corner_first_i);
          if (corner_second_i !== want.c1)
            report_mismatch("corner_second", want.c1, corner_second_i);
          if (corner_third_i !== want.c2)
            report_mismatch("corner_third", want.c2, corner_third_i);
          if (overflow_i !== want.ovf)
            report_mismatch("overflow", want.ovf, overflow_i);
          if (last_i !== want.last)
            report_mismatch("last", want.last, last_i);
          if (want.ovf) ovf_tris++;
        end
        tris++;
      end
      if (in_valid_i && !in_stall_i) begin
        stitch_ring(ring_size_i, new_mesh_i);
        rings++;
      end
      err_count_o     <= errs;
      pending_o       <= tri_q.size();
      ring_count_o    <= rings;
      tri_count_o     <= tris;
      ovf_tri_count_o <= ovf_tris;
    end
  end

endmodule

// ===== dv/tb_loft_ring_stitch_indexer_top.sv =====
module tb_loft_ring_stitch_indexer_top;
  import lrsi_pkg::*;

  localparam int DrainCycles = 8;
  localparam int NumDirected = 22;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             cfg_valid   = 1'b0;
  logic             cfg_ready;
  logic             cfg_data    = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [SizeW-1:0] ring_size   = '0;
  logic             new_mesh    = 1'b0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic [IdxW-1:0]  corner_first;
  logic [IdxW-1:0]  corner_second;
  logic [IdxW-1:0]  corner_third;
  logic             overflow;
  logic             last;

  int err_count;
  int pending;
  int ring_count;
  int tri_count;
  int ovf_tri_count;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int unsigned dir_size [NumDirected] = '{4, 4, 7, 3, 32, 63, 0, 5, 2, 1, 3, 33, 3, 16,
                                          6, 9, 32, 3, 62, 31, 8, 21};
  bit          dir_mesh [NumDirected] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                                          0, 0, 0, 0, 1, 0, 0, 0};
  bit          dir_flat [NumDirected] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                          1, 1, 1, 1, 1, 1, 0, 0};

  loft_ring_stitch_indexer_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .ring_size_i    (ring_size),
    .new_mesh_i     (new_mesh),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .corner_first_o (corner_first),
    .corner_second_o(corner_second),
    .corner_third_o (corner_third),
    .overflow_o     (overflow),
    .last_o         (last)
  );

  loft_ring_stitch_checker u_stitch_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .ring_size_i    (ring_size),
    .new_mesh_i     (new_mesh),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .corner_first_i (corner_first),
    .corner_second_i(corner_second),
    .corner_third_i (corner_third),
    .overflow_i     (overflow),
    .last_i         (last),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .ring_count_o   (ring_count),
    .tri_count_o    (tri_count),
    .ovf_tri_count_o(ovf_tri_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic send_ring(input logic [SizeW-1:0] size, input logic mesh);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    ring_size <= size;
    new_mesh  <= mesh;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SizeW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return SizeW'($urandom_range(0, 2));
    if (r == 1) return SizeW'($urandom_range(33, 63));
    if (r < 6) return SizeW'($urandom_range(3, 8));
    return SizeW'($urandom_range(3, 32));
  endfunction

  initial begin
    logic mode_now;
    mode_now       = 1'b0;
    send_idle_pct  = 17;
    recv_stall_pct = 82;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(1'b0);

    for (int k = 0; k < NumDirected; k++) begin
      if (dir_flat[k] != mode_now) begin
        drain_block();
        mode_now = dir_flat[k];
        write_mode(mode_now);
      end
      send_ring(SizeW'(dir_size[k]), dir_mesh[k]);
    end

    for (int p = 0; p < 3; p++) begin
      send_idle_pct  = (p == 0) ? 17 : (p == 1) ? 82 : 0;
      recv_stall_pct = (p == 0) ? 82 : (p == 1) ? 17 : 0;
      for (int k = 0; k < 100; k++) begin
        if (k % 25 == 0) begin
          drain_block();
          write_mode((p == 0 && k == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
        end
        send_ring(pick_size(), $urandom_range(0, 9) == 0);
      end
    end

    drain_block();
    $display("Run covered %0d rings and %0d triangles in shared and flat numbering,",
             ring_count, tri_count);
    $display("  %0d of them carrying the saturation flag.", ovf_tri_count);
    if (err_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
